FILE: rtl/core/shift_array_insert_delete_find_top_macros.svh
// Assertion macros for the packed insert/delete/find array.
// Used by the port checker; needs i_clk in scope at the point of use.
`ifndef SHIFT_ARRAY_INSERT_DELETE_FIND_TOP_MACROS_SVH
`define SHIFT_ARRAY_INSERT_DELETE_FIND_TOP_MACROS_SVH

// same-cycle implication
`define SADF_AST_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define SADF_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/sadf_pkg.sv
// Shared types and constants for the packed insert/delete/find array.
// No dependencies; imported by every module of the block.
package sadf_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [31:0] t_word;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BEYOND   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic  ins_ok;
        logic  del_ok;
        t_cnt  pos;
        t_cnt  count;
        t_word operand;
    } t_cell_ctrl;

    typedef struct packed {
        logic first;
        logic last;
    } t_hit;

endpackage

FILE: rtl/core/sadf_cell.sv
// One slot of the packed array: holds a word, compares it, shifts with neighbors.
// Depends on sadf_pkg.
module sadf_cell (
    input  logic                i_clk,
    input  sadf_pkg::t_cell_ctrl i_ctrl,
    input  sadf_pkg::t_idx      i_index,
    input  sadf_pkg::t_word     i_lower,
    input  sadf_pkg::t_word     i_upper,
    input  logic                i_below,
    input  logic                i_above,
    output logic                o_below,
    output logic                o_above,
    output sadf_pkg::t_word     o_value,
    output sadf_pkg::t_hit      o_hit
);
    import sadf_pkg::*;

    t_word r_value;
    t_word n_value;
    t_cnt  w_idx;
    logic  w_valid;
    logic  w_match;

    always_comb begin
        w_idx   = CNT_W'(i_index);
        w_valid = (w_idx < i_ctrl.count);
        w_match = w_valid && (r_value == i_ctrl.operand);
        o_below = i_below | w_match;
        o_above = i_above | w_match;
        o_hit.first = w_match & ~i_below;
        o_hit.last  = w_match & ~i_above;
        o_value = r_value;
    end

    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins_ok) begin
            if (w_idx == i_ctrl.pos) begin
                n_value = i_ctrl.operand;
            end else if ((w_idx > i_ctrl.pos) && (w_idx <= i_ctrl.count)) begin
                n_value = i_lower;
            end
        end else if (i_ctrl.del_ok && o_below) begin
            n_value = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: rtl/core/shift_array_insert_delete_find_top.sv
// Top level of the packed insert/delete/find array: control, count and result register.
// Depends on sadf_pkg and sadf_cell.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-----------------------------------------
//  request  | i_in_valid   | o_in_stall   | i_opcode, i_position, i_operand_value
//  result   | o_out_valid  | i_out_stall  | o_new_length, o_found_position, o_status
//
// One request per cycle while o_in_stall is low; its result appears in the cycle after the transfer.
// The row of cells compares and shifts all entries in the transfer cycle.
// Synchronous active-low reset clears the count and the result valid; entries are not cleared.
// A result held by i_out_stall stalls the request side until it is taken.
module shift_array_insert_delete_find_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_opcode,
    input  logic [4:0]            i_position,
    input  logic signed [31:0]    i_operand_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [4:0]            o_new_length,
    output logic [3:0]            o_found_position,
    output logic [1:0]            o_status
);
    import sadf_pkg::*;

    t_cnt       r_count;
    t_cnt       n_count;
    logic       r_out_valid;
    logic [4:0] r_new_length;
    logic [3:0] r_found;
    t_status    r_status;

    logic       w_accept;
    t_opcode    w_op;
    logic       w_full;
    logic       w_beyond;
    logic       w_any;
    t_status    w_status;
    t_idx       w_idx;
    t_idx       w_first_idx;
    t_idx       w_last_idx;
    t_cell_ctrl w_ctrl;

    t_word w_value [DEPTH];
    t_hit  w_hit   [DEPTH];
    logic  w_below [DEPTH+1];
    logic  w_above [DEPTH+1];

    assign o_in_stall = r_out_valid & i_out_stall;

    always_comb begin
        w_accept = i_in_valid & ~o_in_stall;
        w_op     = t_opcode'(i_opcode);
        w_full   = (r_count == CNT_W'(DEPTH));
        w_beyond = (CMP_W'(i_position) > CMP_W'(r_count));
        w_any    = w_below[DEPTH];
    end

    always_comb begin
        w_first_idx = '0;
        w_last_idx  = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (w_hit[k].first) begin
                w_first_idx = w_first_idx | IDX_W'(k);
            end
            if (w_hit[k].last) begin
                w_last_idx = w_last_idx | IDX_W'(k);
            end
        end
    end

    always_comb begin
        w_ctrl.ins_ok  = 1'b0;
        w_ctrl.del_ok  = 1'b0;
        w_ctrl.pos     = CNT_W'(i_position);
        w_ctrl.count   = r_count;
        w_ctrl.operand = i_operand_value;
        w_status       = ST_OK;
        w_idx          = '0;
        unique case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_beyond) begin
                    w_status = ST_BEYOND;
                end else begin
                    w_ctrl.ins_ok = w_accept;
                end
            end
            OP_DELETE: begin
                if (w_any) begin
                    w_ctrl.del_ok = w_accept;
                    w_idx         = w_first_idx;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_FIND: begin
                if (w_any) begin
                    w_idx = w_last_idx;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.del_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_below[0]     = 1'b0;
    assign w_above[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_lower;
        t_word w_upper;

        if (g == 0) begin : g_first
            assign w_lower = i_operand_value;
        end else begin : g_mid_lo
            assign w_lower = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_upper = w_value[g];
        end else begin : g_mid_hi
            assign w_upper = w_value[g+1];
        end

        sadf_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_index (IDX_W'(g)),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .i_below (w_below[g]),
            .i_above (w_above[g+1]),
            .o_below (w_below[g+1]),
            .o_above (w_above[g]),
            .o_value (w_value[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_out_valid <= w_accept | (r_out_valid & i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_new_length <= 5'(n_count);
            r_found      <= 4'(w_idx);
            r_status     <= w_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_new_length     = r_new_length;
    assign o_found_position = r_found;
    assign o_status         = r_status;

endmodule

FILE: rtl/core/sadf_checker.sv
// Port-level checker for the packed insert/delete/find array, bound to the top level.
// Depends on sadf_pkg and the assertion macro header.
`include "shift_array_insert_delete_find_top_macros.svh"

module sadf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [4:0]  o_new_length,
    input logic [3:0]  o_found_position,
    input logic [1:0]  o_status
);
    import sadf_pkg::*;

    `SADF_AST_NXT(a_xfer_gives_result, i_rst_n && i_in_valid && !o_in_stall, o_out_valid)
    `SADF_AST_NXT(a_stalled_result_holds, i_rst_n && o_out_valid && i_out_stall,
        o_out_valid && $stable(o_new_length) && $stable(o_found_position)
        && $stable(o_status))
    `SADF_AST_NOW(a_full_length, o_out_valid && (o_status == ST_FULL), o_new_length == 5'(DEPTH))
    `SADF_AST_NOW(a_notfound_index, o_out_valid && (o_status == ST_NOTFOUND), o_found_position == 4'd0)

endmodule

bind shift_array_insert_delete_find_top sadf_checker u_sadf_checker (.*);

FILE: tb/sv/shift_array_insert_delete_find_top_test.sv
// Self-checking testbench for shift_array_insert_delete_find_top: insert, delete and find
// requests checked against a local model of the packed array. Depends on sadf_pkg and the RTL.
module shift_array_insert_delete_find_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sadf_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CHECK_SIDE = 0;
    localparam int GEN_SIDE = 1;
    localparam int REPORT_LIMIT = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] position;
        t_word      value;
    } t_request;

    typedef struct packed {
        logic [4:0] new_length;
        logic [3:0] found_position;
        t_status    status;
    } t_outcome;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [1:0]        i_opcode;
    logic [4:0]        i_position;
    logic signed [31:0] i_operand_value;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [4:0]        o_new_length;
    logic [3:0]        o_found_position;
    logic [1:0]        o_status;

    t_word    shadow_words [2][DEPTH];
    int       shadow_count [2] = '{0, 0};
    t_request requests_to_send [$];
    t_outcome outcomes_due [$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    bit       request_taken = 1'b0;
    bit       timed_out = 1'b0;
    int       idle_cycles = 0;
    int       failures = 0;
    int       outcome_index = 0;

    shift_array_insert_delete_find_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_position       (i_position),
        .i_operand_value  (i_operand_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_new_length     (o_new_length),
        .o_found_position (o_found_position),
        .o_status         (o_status)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_outcome array_op_outcome(input int side, input t_request req);
        t_outcome res;
        int hit;
        res.found_position = '0;
        res.status = ST_OK;
        hit = -1;
        case (req.opcode)
            OP_INSERT: begin
                if (shadow_count[side] >= DEPTH) begin
                    res.status = ST_FULL;
                end else if (int'(req.position) > shadow_count[side]) begin
                    res.status = ST_BEYOND;
                end else begin
                    for (int i = shadow_count[side]; i > int'(req.position); i--)
                        shadow_words[side][i] = shadow_words[side][i-1];
                    shadow_words[side][req.position[3:0]] = req.value;
                    shadow_count[side]++;
                end
            end
            OP_DELETE: begin
                for (int i = 0; i < shadow_count[side]; i++)
                    if (hit < 0 && shadow_words[side][i] == req.value)
                        hit = i;
                if (hit < 0) begin
                    res.status = ST_NOTFOUND;
                end else begin
                    for (int i = hit; i + 1 < shadow_count[side]; i++)
                        shadow_words[side][i] = shadow_words[side][i+1];
                    shadow_count[side]--;
                    res.found_position = hit[3:0];
                end
            end
            OP_FIND: begin
                for (int i = 0; i < shadow_count[side]; i++)
                    if (shadow_words[side][i] == req.value)
                        hit = i;
                if (hit < 0)
                    res.status = ST_NOTFOUND;
                else
                    res.found_position = hit[3:0];
            end
            default: ;
        endcase
        res.new_length = shadow_count[side][4:0];
        return res;
    endfunction

    function automatic t_word pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45 && shadow_count[GEN_SIDE] > 0)
            return shadow_words[GEN_SIDE][$urandom_range(0, shadow_count[GEN_SIDE] - 1)];
        if (roll < 75)
            return t_word'($urandom_range(0, 7)) - 4;
        if (roll < 85)
            return ($urandom_range(0, 1) != 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        return t_word'($urandom);
    endfunction

    task automatic queue_request(input logic [1:0] op, input logic [4:0] pos, input t_word value);
        t_request req;
        t_outcome ignored;
        req = {op, pos, value};
        ignored = array_op_outcome(GEN_SIDE, req);
        requests_to_send.push_back(req);
    endtask

    task automatic queue_random(input int count);
        int roll;
        int ins_pct;
        logic [1:0] op;
        logic [4:0] pos;
        for (int k = 0; k < count; k++) begin
            ins_pct = ((k / 40) % 2 == 0) ? 70 : 30;
            roll = $urandom_range(0, 99);
            pos = 5'($urandom_range(0, 31));
            if (roll < 4) begin
                op = OP_UNUSED;
            end else if (roll < ins_pct) begin
                op = OP_INSERT;
                if ($urandom_range(0, 9) != 0)
                    pos = 5'($urandom_range(0, shadow_count[GEN_SIDE]));
            end else if (roll < ins_pct + (100 - ins_pct) / 2) begin
                op = OP_DELETE;
            end else begin
                op = OP_FIND;
            end
            queue_request(op, pos, pick_value());
        end
    endtask

    task automatic wait_for_drain();
        while ((requests_to_send.size() != 0 || i_in_valid || outcomes_due.size() != 0)
               && !timed_out)
            @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        t_request next_req;
        if (i_rst_n) begin
            if (!i_in_valid || request_taken) begin
                if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = requests_to_send.pop_front();
                    i_opcode <= next_req.opcode;
                    i_position <= next_req.position;
                    i_operand_value <= next_req.value;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_request seen;
        t_outcome want;
        bit result_taken;
        if (i_rst_n) begin
            request_taken = i_in_valid && !o_in_stall;
            result_taken = o_out_valid && !i_out_stall;
            if (result_taken) begin
                if (outcomes_due.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result: length %0d position %0d status %0d",
                                 o_new_length, o_found_position, o_status);
                end else begin
                    want = outcomes_due.pop_front();
                    if (o_new_length !== want.new_length
                        || o_found_position !== want.found_position
                        || o_status !== want.status) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display({"result %0d mismatch: expected length %0d position %0d ",
                                      "status %0d, got length %0d position %0d status %0d"},
                                     outcome_index, want.new_length, want.found_position,
                                     want.status, o_new_length, o_found_position, o_status);
                    end
                end
                outcome_index++;
            end
            if (request_taken) begin
                seen = {i_opcode, i_position, i_operand_value};
                outcomes_due.push_back(array_op_outcome(CHECK_SIDE, seen));
            end
            if (request_taken || result_taken)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
                timed_out = 1'b1;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_opcode = '0;
        i_position = '0;
        i_operand_value = '0;
        i_out_stall = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 29;
        recv_idle_pct = 69;
        queue_request(OP_FIND, 5'd0, 32'sd5);
        queue_request(OP_DELETE, 5'd0, 32'sd5);
        queue_request(OP_INSERT, 5'd1, 32'sd1);
        queue_request(OP_INSERT, 5'd0, 32'sh7FFFFFFF);
        queue_request(OP_INSERT, 5'd1, 32'sh80000000);
        queue_request(OP_INSERT, 5'd0, -32'sd1);
        queue_request(OP_INSERT, 5'd1, 32'sd7);
        queue_request(OP_INSERT, 5'd4, 32'sd7);
        queue_request(OP_FIND, 5'd31, 32'sd7);
        queue_request(OP_DELETE, 5'd31, 32'sd7);
        for (int k = 0; k < 12; k++)
            queue_request(OP_INSERT, 5'(4 + k), t_word'(100 + k));
        queue_request(OP_INSERT, 5'd16, 32'sd3);
        queue_request(OP_INSERT, 5'd31, 32'sd3);
        queue_request(OP_UNUSED, 5'd31, -32'sd1);
        queue_request(OP_FIND, 5'd0, 32'sd111);
        queue_request(OP_DELETE, 5'd0, 32'sd111);
        queue_random(130);
        wait_for_drain();

        send_idle_pct = 69;
        recv_idle_pct = 29;
        queue_random(130);
        wait_for_drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(140);
        wait_for_drain();
        repeat (4) @(posedge i_clk);

        if (outcomes_due.size() != 0) begin
            failures += outcomes_due.size();
            $display("%0d results never arrived", outcomes_due.size());
        end
        if (failures == 0 && !timed_out)
            $display("shift_array_insert_delete_find_top_test passed");
        else
            $display("shift_array_insert_delete_find_top_test failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sadf_pkg.sv
rtl/core/sadf_cell.sv
rtl/core/shift_array_insert_delete_find_top.sv
rtl/core/sadf_checker.sv
tb/sv/shift_array_insert_delete_find_top_test.sv
